FILE: src/flow_vector_to_speed_angle_unit_defines.svh
// Assertion macros shared by the port checker.
// The macros expect clk and rst_n to be visible in the scope that uses them.
`ifndef FLOW_VECTOR_TO_SPEED_ANGLE_UNIT_DEFINES_SVH
`define FLOW_VECTOR_TO_SPEED_ANGLE_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FVSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow vector unit: port check failed");

// Check cons a fixed number of cycles after ante.
`define FVSA_ASSERT_LATER(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("flow vector unit: delayed port check failed");

`endif

FILE: src/fvsa_pkg.sv
package fvsa_pkg;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
  } flow_req_t;

  typedef struct packed {
    logic [7:0] speed_code;
    logic [7:0] angle_code;
  } flow_res_t;

  // CORDIC datapath word: Q7.8 input scaled by 2^14 plus headroom for the gain
  localparam int CORDIC_W = 34;
  localparam int PRESCALE_SHIFT = 14;
  localparam int ATAN_LEN = 24;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic [31:0]                z;
    logic                       y_zero;
    logic                       x_neg;
    logic                       y_neg;
  } cord_t;

  // Binary angle: 2^32 is one full turn
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
  localparam logic [31:0] JUST_BELOW_PI = 32'h7FFF_FFFF;

  localparam logic [7:0] ANGLE_ZERO = 8'd127;
  localparam logic [7:0] ANGLE_PI   = 8'd255;
  localparam logic [7:0] SPEED_MAX  = 8'd255;

  // Integer square root of a 16-bit radicand, two steps per cell
  localparam int SQRT_CELLS = 4;
  localparam int SQRT_STEPS = 2;
  localparam int SQRT_TOP_BIT = 14;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
    logic        sat;
  } sqrt_t;

  // Edges from accept to a finished speed code at the sqrt chain output
  localparam int SPEED_LATENCY = 3 + SQRT_CELLS;

endpackage

FILE: src/flow_vector_to_speed_angle_unit.sv
// Converts one optical-flow vector (signed Q7.8 x and y) into a speed byte
// and a direction byte. A request is taken at every clock edge where start is
// high and busy is low; busy is high only for the first cycle after reset, so
// a new request may be presented every cycle. Each request produces exactly
// one result: out_strobe is high for a single cycle when its result has
// reached the output register, and out_data is valid only in that cycle. The
// receiver cannot hold results off, so it must capture every strobed result.
// Latency is set by the CORDIC chain: one input cell, one cell per
// micro-rotation, one output register. The speed byte comes from a shorter
// square-root chain (squares, sum, scale by 65025, four two-bit root cells)
// and is delayed to line up with the angle. Speed saturates at 255; a zero
// vector gives angle 127, a vector on the negative x axis gives 255.
module flow_vector_to_speed_angle_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fvsa_pkg::flow_req_t in_data,
  output logic                out_strobe,
  output fvsa_pkg::flow_res_t out_data
);

  localparam int SPD_DLY = CORDIC_STAGES + 1 - fvsa_pkg::SPEED_LATENCY;

  logic accept;
  logic busy_r;

  // Hold off requests for one cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // ---------------------------------------------------------------- angle
  logic            pre_vld_r;
  fvsa_pkg::cord_t pre_r;
  fvsa_pkg::cord_t pre_nxt;

  // Scale to the CORDIC word; turn left half-plane vectors by pi
  always_comb begin
    logic signed [fvsa_pkg::CORDIC_W-1:0] cx0;
    logic signed [fvsa_pkg::CORDIC_W-1:0] cy0;
    cx0 = fvsa_pkg::CORDIC_W'(in_data.flow_x) <<< fvsa_pkg::PRESCALE_SHIFT;
    cy0 = fvsa_pkg::CORDIC_W'(in_data.flow_y) <<< fvsa_pkg::PRESCALE_SHIFT;
    pre_nxt.y_zero = (in_data.flow_y == 16'sd0);
    pre_nxt.x_neg  = in_data.flow_x[15];
    pre_nxt.y_neg  = in_data.flow_y[15];
    if (in_data.flow_x[15]) begin
      pre_nxt.cx = -cx0;
      pre_nxt.cy = -cy0;
      pre_nxt.z  = fvsa_pkg::HALF_TURN;
    end else begin
      pre_nxt.cx = cx0;
      pre_nxt.cy = cy0;
      pre_nxt.z  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  logic            cord_vld [CORDIC_STAGES+1];
  fvsa_pkg::cord_t cord_st  [CORDIC_STAGES+1];

  assign cord_vld[0] = pre_vld_r;
  assign cord_st[0]  = pre_r;

  // Advance through one micro-rotation per cell
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    fvsa_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (cord_vld[i]),
      .in_st  (cord_st[i]),
      .out_vld(cord_vld[i+1]),
      .out_st (cord_st[i+1])
    );
  end

  fvsa_pkg::cord_t last_st;
  logic [31:0]     z_fix;
  logic [31:0]     u_ang;
  logic [39:0]     ang_prod;
  logic [7:0]      angle_nxt;

  assign last_st = cord_st[CORDIC_STAGES];

  // Clamp residue that lands in the half-plane opposite to the sign of y
  always_comb begin
    z_fix = last_st.z;
    if (!last_st.y_zero && !last_st.y_neg && last_st.z >= fvsa_pkg::HALF_TURN) begin
      z_fix = (last_st.z >= fvsa_pkg::THREE_QUARTER) ? 32'd0 : fvsa_pkg::JUST_BELOW_PI;
    end else if (last_st.y_neg && last_st.z != 32'd0 && last_st.z < fvsa_pkg::HALF_TURN) begin
      z_fix = (last_st.z < fvsa_pkg::QUARTER_TURN) ? 32'd0 : fvsa_pkg::HALF_TURN;
    end
  end

  // Map the binary angle to 0..255: (u * 255) >> 32 as shift and subtract
  assign u_ang    = z_fix + fvsa_pkg::HALF_TURN;
  assign ang_prod = {u_ang, 8'd0} - {8'd0, u_ang};

  always_comb begin
    if (last_st.y_zero) begin
      angle_nxt = last_st.x_neg ? fvsa_pkg::ANGLE_PI : fvsa_pkg::ANGLE_ZERO;
    end else begin
      angle_nxt = ang_prod[39:32];
    end
  end

  // ---------------------------------------------------------------- speed
  logic [30:0] sq_x_r;
  logic [30:0] sq_y_r;
  logic [31:0] sum_r;
  logic [47:0] scaled;
  logic [15:0] rad_r;
  logic        sat_r;

  // x*x and y*y of the raw Q7.8 values
  always_ff @(posedge clk) begin
    sq_x_r <= 31'(in_data.flow_x * in_data.flow_x);
    sq_y_r <= 31'(in_data.flow_y * in_data.flow_y);
  end

  always_ff @(posedge clk) begin
    sum_r <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
  end

  // S * 65025 = S * 2^16 - S * 2^9 + S; drop 20 bits so the root drops 10
  assign scaled = {sum_r, 16'd0} - {7'd0, sum_r, 9'd0} + {16'd0, sum_r};

  always_ff @(posedge clk) begin
    rad_r <= scaled[35:20];
    sat_r <= |scaled[47:36];
  end

  fvsa_pkg::sqrt_t sq_st [fvsa_pkg::SQRT_CELLS+1];

  assign sq_st[0].rem  = rad_r;
  assign sq_st[0].root = '0;
  assign sq_st[0].sat  = sat_r;

  for (genvar c = 0; c < fvsa_pkg::SQRT_CELLS; c++) begin : g_sqrt
    fvsa_sqrt_cell #(
      .CELL(c)
    ) u_cell (
      .clk   (clk),
      .in_st (sq_st[c]),
      .out_st(sq_st[c+1])
    );
  end

  logic [7:0] speed_raw;
  logic [7:0] spd_dly_r [SPD_DLY];

  assign speed_raw = sq_st[fvsa_pkg::SQRT_CELLS].sat ? fvsa_pkg::SPEED_MAX
                   : sq_st[fvsa_pkg::SQRT_CELLS].root[7:0];

  // Delay the speed code to line up with the angle chain
  always_ff @(posedge clk) begin
    spd_dly_r[0] <= speed_raw;
    for (int k = 1; k < SPD_DLY; k++) begin
      spd_dly_r[k] <= spd_dly_r[k-1];
    end
  end

  // ---------------------------------------------------------------- output
  logic                out_strobe_r;
  fvsa_pkg::flow_res_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cord_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.speed_code <= spd_dly_r[SPD_DLY-1];
    out_data_r.angle_code <= angle_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: src/fvsa_cordic_cell.sv
module fvsa_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  fvsa_pkg::cord_t in_st,
  output logic            out_vld,
  output fvsa_pkg::cord_t out_st
);

  logic            vld_r;
  fvsa_pkg::cord_t st_r;
  fvsa_pkg::cord_t st_nxt;

  // One vectoring micro-rotation: drive y toward zero
  always_comb begin
    logic signed [fvsa_pkg::CORDIC_W-1:0] dx;
    logic signed [fvsa_pkg::CORDIC_W-1:0] dy;
    dx = in_st.cy >>> SHIFT;
    dy = in_st.cx >>> SHIFT;
    st_nxt = in_st;
    if (!in_st.cy[fvsa_pkg::CORDIC_W-1]) begin
      st_nxt.cx = in_st.cx + dx;
      st_nxt.cy = in_st.cy - dy;
      st_nxt.z  = in_st.z + fvsa_pkg::ATAN_TAB[SHIFT];
    end else begin
      st_nxt.cx = in_st.cx - dx;
      st_nxt.cy = in_st.cy + dy;
      st_nxt.z  = in_st.z - fvsa_pkg::ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_vld = vld_r;
  assign out_st  = st_r;

endmodule

FILE: src/fvsa_sqrt_cell.sv
module fvsa_sqrt_cell #(
  parameter int CELL = 0
) (
  input  logic            clk,
  input  fvsa_pkg::sqrt_t in_st,
  output fvsa_pkg::sqrt_t out_st
);

  fvsa_pkg::sqrt_t st_r;
  fvsa_pkg::sqrt_t st_nxt;

  // Restoring square root, two result bits per cell
  always_comb begin
    logic [15:0] rem_v;
    logic [15:0] res_v;
    logic [15:0] bit_v;
    logic [16:0] trial;
    rem_v = in_st.rem;
    res_v = in_st.root;
    for (int j = 0; j < fvsa_pkg::SQRT_STEPS; j++) begin
      bit_v = 16'(1) << (fvsa_pkg::SQRT_TOP_BIT - 2 * (CELL * fvsa_pkg::SQRT_STEPS + j));
      trial = {1'b0, res_v} + {1'b0, bit_v};
      if ({1'b0, rem_v} >= trial) begin
        rem_v = rem_v - trial[15:0];
        res_v = (res_v >> 1) + bit_v;
      end else begin
        res_v = res_v >> 1;
      end
    end
    st_nxt.rem  = rem_v;
    st_nxt.root = res_v;
    st_nxt.sat  = in_st.sat;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_st = st_r;

endmodule

FILE: src/fvsa_port_check.sv
`include "flow_vector_to_speed_angle_unit_defines.svh"

module fvsa_port_check #(
  parameter int CORDIC_STAGES = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input fvsa_pkg::flow_req_t in_data,
  input logic                out_strobe,
  input fvsa_pkg::flow_res_t out_data
);

  localparam int LAT = CORDIC_STAGES + 2;

  logic accept;
  logic zero_req;
  logic zero_res;

  assign accept   = start && !busy;
  assign zero_req = accept && (in_data.flow_x == 16'sd0) && (in_data.flow_y == 16'sd0);
  assign zero_res = (out_data.speed_code == 8'd0) &&
                    (out_data.angle_code == fvsa_pkg::ANGLE_ZERO);

  // After the first cycle out of reset, requests are never held off
  `FVSA_ASSERT_NOW(a_busy_low, $past(rst_n), !busy)

  // Every request yields a strobe after the fixed latency
  `FVSA_ASSERT_LATER(a_req_to_res, accept, LAT, out_strobe)

  // No strobe without a request the fixed latency earlier
  `FVSA_ASSERT_NOW(a_res_from_req, out_strobe, $past(accept, LAT))

  // Zero vector: no speed, angle at mid scale
  `FVSA_ASSERT_LATER(a_zero_vec, zero_req, LAT, zero_res)

endmodule

bind flow_vector_to_speed_angle_unit fvsa_port_check #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_port_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

FILE: sim/flow_vector_to_speed_angle_unit_test.sv
`timescale 1ns / 1ps

module flow_vector_to_speed_angle_unit_test;

  localparam int STAGES      = 16;
  localparam int SETTLE      = STAGES + 8;       // edges to wait past the last strobe
  localparam int DRAIN_LIMIT = 20 * (STAGES + 2);
  localparam int RANDOM_PER_PHASE = 550;
  localparam int PHASES = 3;
  localparam int IDLE_PCT [PHASES] = '{0, 45, 14};

  // Binary-angle arctangent steps: atan(2^-i) scaled so 2^32 is one turn.
  localparam bit [31:0] ARCTAN_BAM [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };
  localparam bit [31:0] BAM_HALF     = 32'h8000_0000;
  localparam bit [31:0] BAM_QUARTER  = 32'h4000_0000;
  localparam bit [31:0] BAM_3QUARTER = 32'hC000_0000;
  localparam bit [31:0] BAM_BELOW_PI = 32'h7FFF_FFFF;
  localparam bit [7:0]  CODE_ANGLE_ZERO = 8'd127;
  localparam bit [7:0]  CODE_ANGLE_PI   = 8'd255;
  localparam bit [7:0]  CODE_SPEED_TOP  = 8'd255;

  // Directed vectors: corners, axes, unit steps, the 4 px/frame speed knee
  // and near-axis vectors that stress the half-plane clamp.
  localparam int N_DIRECTED = 25;
  localparam int DIR_X [N_DIRECTED] = '{
    32767, -32768, -32768, 32767, 0, 0, 0, -32768, 32767,
    1, -1, 0, 0, 1, -1, -1, 1,
    1024, 1023, -1024, 0,
    32767, 32767, -32768, -32768};
  localparam int DIR_Y [N_DIRECTED] = '{
    32767, -32768, 0, 0, 0, 32767, -32768, 32767, -32768,
    0, 0, 1, -1, 1, -1, 1, -1,
    0, 0, 0, 725,
    1, -1, 1, -1};

  // Expected-result store with its own speed/angle predictor.
  class flow_scoreboard;
    fvsa_pkg::flow_res_t pending_codes[$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function fvsa_pkg::flow_res_t predict_speed_angle(fvsa_pkg::flow_req_t v);
      longint              x, y, cx, cy, dx, dy;
      longint unsigned     sum_sq, rad, root, bitv;
      bit [31:0]           z, u;
      bit [63:0]           scaled;
      fvsa_pkg::flow_res_t r;
      x = longint'($signed(v.flow_x));
      y = longint'($signed(v.flow_y));

      // Speed: exact integer square root of (x^2 + y^2) * 255^2.
      sum_sq = longint'(x * x) + longint'(y * y);
      rad    = sum_sq * 64'd65025;
      root   = 0;
      bitv   = 64'd1 << 62;
      while (bitv > rad) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rad >= root + bitv) begin
          rad  = rad - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      root = root / 1024;
      r.speed_code = (root > 255) ? CODE_SPEED_TOP : root[7:0];

      // Angle: vectoring CORDIC on a 32-bit binary angle.
      if (y == 0) begin
        r.angle_code = (x < 0) ? CODE_ANGLE_PI : CODE_ANGLE_ZERO;
        return r;
      end
      cx = x * 16384;
      cy = y * 16384;
      z  = '0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z  = BAM_HALF;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z  = z + ARCTAN_BAM[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z  = z - ARCTAN_BAM[i];
        end
      end
      if (y > 0 && z >= BAM_HALF)
        z = (z >= BAM_3QUARTER) ? 32'd0 : BAM_BELOW_PI;
      else if (y < 0 && z != 0 && z < BAM_HALF)
        z = (z < BAM_QUARTER) ? 32'd0 : BAM_HALF;
      u      = z + BAM_HALF;
      scaled = (64'(u) * 64'd255) >> 32;
      r.angle_code = scaled[7:0];
      return r;
    endfunction

    function void note_request(fvsa_pkg::flow_req_t v);
      pending_codes.push_back(predict_speed_angle(v));
    endfunction

    task check_result(fvsa_pkg::flow_res_t got);
      fvsa_pkg::flow_res_t want;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected result speed=%0d angle=%0d",
                         got.speed_code, got.angle_code));
        return;
      end
      want = pending_codes.pop_front();
      if (got.speed_code !== want.speed_code)
        report($sformatf("speed_code got %0d want %0d", got.speed_code, want.speed_code));
      if (got.angle_code !== want.angle_code)
        report($sformatf("angle_code got %0d want %0d", got.angle_code, want.angle_code));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fvsa_pkg::flow_req_t in_data;
  logic                out_strobe;
  fvsa_pkg::flow_res_t out_data;

  flow_scoreboard sb;

  flow_vector_to_speed_angle_unit #(
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Capture every strobed result; the block cannot be held off, so check
  // each one at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      sb.check_result(out_data);
  end

  function automatic fvsa_pkg::flow_req_t make_vector(int x, int y);
    fvsa_pkg::flow_req_t v;
    v.flow_x = x[15:0];
    v.flow_y = y[15:0];
    return v;
  endfunction

  // Pick a vector: small vectors around the speed knee, plus full range, axes,
  // near-axis vectors and field extremes.
  function automatic fvsa_pkg::flow_req_t random_vector();
    int pick, a, b, sel;
    int corner [5] = '{-32768, -1, 0, 1, 32767};
    pick = $urandom_range(99);
    if (pick < 40) begin
      a = int'($urandom_range(2200)) - 1100;
      b = int'($urandom_range(2200)) - 1100;
    end else if (pick < 60) begin
      a = int'($urandom);
      b = int'($urandom);
    end else if (pick < 75) begin
      a = int'($urandom);
      b = 0;
    end else if (pick < 90) begin
      a = int'($urandom_range(65535)) - 32768;
      b = int'($urandom_range(6)) - 3;
    end else begin
      a = corner[$urandom_range(4)];
      b = corner[$urandom_range(4)];
    end
    // Swap roles half the time so both components see every shape.
    sel = $urandom_range(1);
    return sel ? make_vector(b, a) : make_vector(a, b);
  endfunction

  // Present one request after a random gap; hold it until accepted.
  task automatic send_vector(fvsa_pkg::flow_req_t v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      // drop start and wiggle the data bus to show it is ignored
      start   <= 1'b0;
      in_data <= fvsa_pkg::flow_req_t'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(v);
  endtask

  // Hold off new requests until every expected result has come back.
  task automatic drain_results();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (sb.pending_codes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    sb      = new();
    clk     = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests, back to back.
    for (int i = 0; i < N_DIRECTED; i++)
      send_vector(make_vector(DIR_X[i], DIR_Y[i]), 0);
    drain_results();

    // Random requests in phases of different sender idling; drain the
    // pipeline fully between phases.
    for (int p = 0; p < PHASES; p++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_vector(random_vector(), IDLE_PCT[p]);
      drain_results();
    end

    if (sb.pending_codes.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_codes.size()));
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/fvsa_pkg.sv
src/fvsa_cordic_cell.sv
src/fvsa_sqrt_cell.sv
src/flow_vector_to_speed_angle_unit.sv
src/fvsa_port_check.sv
sim/flow_vector_to_speed_angle_unit_test.sv
